// File: hw/rtl/brsm_pkg.sv
// shared types and constants for the batch rank-select median filter
package brsm_pkg;

  localparam int unsigned SAMPLE_W = 9;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 9'd359;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } brsm_emit_t;

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] s);
    return (s > SAMPLE_MAX) ? SAMPLE_MAX : s;
  endfunction

endpackage

// File: hw/rtl/brsm_mem.sv
// sample memory: one write port, one read port with registered read data
module brsm_mem import brsm_pkg::*; #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned IW    = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IW-1:0]       waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic                re,
  input  logic [IW-1:0]       raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/brsm_seq.sv
// sequencer: sorted insertion into the sample memory and rank readout
module brsm_seq import brsm_pkg::*; #(
  parameter int unsigned BATCH_SIZE = 10,
  parameter int unsigned IW         = 4,
  parameter int unsigned RANK_IDX   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                out_free,
  output brsm_emit_t          emit,
  output logic                mem_we,
  output logic [IW-1:0]       mem_waddr,
  output logic [SAMPLE_W-1:0] mem_wdata,
  output logic                mem_re,
  output logic [IW-1:0]       mem_raddr,
  input  logic [SAMPLE_W-1:0] mem_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_PLACE = 5'b00100,
    ST_RANK  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(BATCH_SIZE - 1);

  state_t              state_r, state_nxt;
  logic [IW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] key_r, key_nxt;
  logic                finish;
  logic [SAMPLE_W-1:0] clamped;

  assign clamped  = clamp_sample(in_sample);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    finish     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = key_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    emit.valid = 1'b0;
    emit.value = mem_rdata;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt = clamped;
          if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_wdata = clamped;
            finish    = 1'b1;
          end else begin
            pos_nxt   = count_r;
            mem_re    = 1'b1;
            mem_raddr = count_r - IW'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (mem_rdata > key_r) begin
          // shift the larger entry up one place
          mem_wdata = mem_rdata;
          if (pos_r == IW'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            pos_nxt   = pos_r - IW'(1);
            mem_re    = 1'b1;
            mem_raddr = pos_r - IW'(2);
          end
        end else begin
          finish = 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we = 1'b1;
        finish = 1'b1;
      end
      ST_RANK: begin
        mem_re    = 1'b1;
        mem_raddr = IW'(RANK_IDX);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit.valid = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      if (count_r == LAST_IDX) begin
        count_nxt = '0;
        state_nxt = ST_RANK;
      end else begin
        count_nxt = count_r + IW'(1);
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
  end

endmodule

// File: hw/rtl/batch_rank_select_median.sv
// top level of the batch rank-select median filter
//
//  channel | ports                               | dir | word
//  --------+-------------------------------------+-----+-------------------------------
//  in      | in_valid, in_ready, in_sample[8:0]  | in  | one bearing, clamped to 359
//  out     | out_valid, out_ready,               | out | value of rank SELECT_RANK in
//          | out_median_value[8:0]               |     | the sorted completed batch
//
// each word is inserted into the sorted memory by a walk from the top of the batch:
// one read-compare-write per cycle, shifting each larger entry up one place until
// the word's place is found; the word that completes a batch then passes through a
// rank read and an emit state that loads the ranked entry into the output register
// synchronous active-low reset clears the fill count, the sequencer and the output
// valid; memory contents are left as they are
// a stalled output holds its word; the next batch keeps loading meanwhile, and once
// its final word is in, the input stays off until the output register is free
module batch_rank_select_median import brsm_pkg::*; #(
  parameter int unsigned BATCH_SIZE  = 10,
  parameter int unsigned SELECT_RANK = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] out_median_value
);

  // address width of the sample memory
  localparam int unsigned IW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  // a rank beyond the batch selects the largest entry
  localparam int unsigned RANK_IDX = (SELECT_RANK >= BATCH_SIZE) ? BATCH_SIZE - 1 : SELECT_RANK;

  brsm_emit_t          emit;
  logic                out_free;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata, mem_rdata;

  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;

  // output register is free when empty or drained this cycle
  assign out_free = !out_valid_r || out_ready;

  brsm_seq #(
    .BATCH_SIZE (BATCH_SIZE),
    .IW         (IW),
    .RANK_IDX   (RANK_IDX)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_free  (out_free),
    .emit      (emit),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // sorted batch lives here
  brsm_mem #(
    .DEPTH (BATCH_SIZE),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loads on emit, clears when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = emit.value;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_value_r;

endmodule

// File: hw/rtl/brsm_checker.sv
// port-level checks for the batch rank-select median filter, bound to the top level
module brsm_checker import brsm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SAMPLE_W-1:0] out_median_value
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median_value))
    else $error("result changed while stalled");

  // result stays within bearing range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_median_value <= SAMPLE_MAX)
    else $error("result above bearing range");

  // a new result appears just as the block returns to ready after the rank read
  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result appeared outside the rank readout");

  // ready without a word stays ready
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("ready dropped without an accepted word");

endmodule

bind batch_rank_select_median brsm_checker u_brsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_median_value (out_median_value)
);
